// ----- rtl/core/csr_pkg.sv -----
// Shared types and constants for the Condorcet/Schulze ranking unit.
// Used by csr_ctrl, csr_dp and the top level; no dependencies.
package csr_pkg;

  localparam int NUM_CAND  = 16;
  localparam int IDX_W     = 4;
  localparam int PAIR_W    = 2 * IDX_W;
  localparam int NUM_PAIRS = NUM_CAND * NUM_CAND;
  localparam int CNT_W     = 16;
  localparam int VAL_W     = 8;
  localparam int CFG_W     = 5;
  localparam int PLACE_W   = 5;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_CAND - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(NUM_CAND);

  localparam logic CMD_BALLOT = 1'b0;
  localparam logic CMD_RANK   = 1'b1;

  localparam logic METHOD_CONDORCET = 1'b0;
  localparam logic METHOD_SCHULZE   = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_CR_RD, S_CR_CMP, S_CR_WR, S_BAL_CLR,
    S_RK_START, S_CP_INIT, S_CP_RD, S_CP_ACC, S_CP_DONE,
    S_ST_RD, S_ST_WR, S_FL_RDA, S_FL_LDA, S_FL_RD, S_FL_WR,
    S_SET_STR, S_EMIT, S_ROUND_END, S_CLEAR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CR_RD, OP_CR_CMP, OP_CR_WR, OP_BAL_CLR,
    OP_RK_START, OP_CP_INIT, OP_CP_RD, OP_CP_ACC,
    OP_ST_RD, OP_ST_WR, OP_FL_RDA, OP_FL_LDA, OP_FL_RD, OP_FL_WR,
    OP_SET_STR, OP_EMIT, OP_ROUND_END, OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] cj;
    logic [IDX_W-1:0] ck;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic win_multi;
    logic use_str;
    logic win_e;
    logic out_free;
    logic round_done;
  } dp_stat_t;

endpackage

// ----- rtl/core/csr_ctrl.sv -----
// Sequencer for the ranking unit: walks ballot credit, Copeland, Schulze
// and emit loops and drives csr_dp through dp_cmd_t. Depends on csr_pkg.
module csr_ctrl import csr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     item_cmd,
  input  logic     item_ballot_end,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  dcmd
);

  state_t state, state_next;
  logic [IDX_W-1:0] ci, cj, ck;
  logic [IDX_W-1:0] ci_next, cj_next, ck_next;
  logic emit_adv;

  assign emit_adv = !stat.win_e || stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ci    <= '0;
      cj    <= '0;
      ck    <= '0;
    end else begin
      state <= state_next;
      ci    <= ci_next;
      cj    <= cj_next;
      ck    <= ck_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (item_cmd == CMD_RANK) state_next = S_RK_START;
          else if (item_ballot_end) state_next = S_CR_RD;
        end
      end
      S_CR_RD:    state_next = S_CR_CMP;
      S_CR_CMP:   state_next = S_CR_WR;
      S_CR_WR:    state_next = ({ci, cj} == '1) ? S_BAL_CLR : S_CR_RD;
      S_BAL_CLR:  state_next = S_IDLE;
      S_RK_START: state_next = stat.n_zero ? S_CLEAR : S_CP_INIT;
      S_CP_INIT:  state_next = S_CP_RD;
      S_CP_RD:    state_next = S_CP_ACC;
      S_CP_ACC:   state_next = ({ci, cj} == '1) ? S_CP_DONE : S_CP_RD;
      S_CP_DONE:  state_next = (stat.win_multi && !stat.use_str) ? S_ST_RD : S_EMIT;
      S_ST_RD:    state_next = S_ST_WR;
      S_ST_WR:    state_next = ({ci, cj} == '1) ? S_FL_RDA : S_ST_RD;
      S_FL_RDA:   state_next = S_FL_LDA;
      S_FL_LDA:   state_next = S_FL_RD;
      S_FL_RD:    state_next = S_FL_WR;
      S_FL_WR: begin
        if (ck == IDX_LAST) state_next = ({ci, cj} == '1) ? S_SET_STR : S_FL_RDA;
        else state_next = S_FL_RD;
      end
      S_SET_STR:  state_next = S_CP_INIT;
      S_EMIT:     state_next = (emit_adv && ck == '0) ? S_ROUND_END : S_EMIT;
      S_ROUND_END: state_next = stat.round_done ? S_CLEAR : S_CP_INIT;
      S_CLEAR:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // loop counters; pair loops wrap back to zero at their end
  always_comb begin
    ci_next = ci;
    cj_next = cj;
    ck_next = ck;
    unique case (state)
      S_IDLE, S_CP_INIT: begin
        ci_next = '0;
        cj_next = '0;
      end
      S_CR_WR, S_CP_ACC, S_ST_WR: {ci_next, cj_next} = {ci, cj} + PAIR_W'(1);
      S_CP_DONE: ck_next = (stat.win_multi && !stat.use_str) ? '0 : IDX_LAST;
      S_FL_WR: begin
        ck_next = ck + IDX_W'(1);
        if (ck == IDX_LAST) {ci_next, cj_next} = {ci, cj} + PAIR_W'(1);
      end
      S_EMIT: if (emit_adv) ck_next = ck - IDX_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    dcmd.ci = ci;
    dcmd.cj = cj;
    dcmd.ck = ck;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        dcmd.op  = OP_ACCEPT;
        in_ready = 1'b1;
      end
      S_CR_RD:     dcmd.op = OP_CR_RD;
      S_CR_CMP:    dcmd.op = OP_CR_CMP;
      S_CR_WR:     dcmd.op = OP_CR_WR;
      S_BAL_CLR:   dcmd.op = OP_BAL_CLR;
      S_RK_START:  dcmd.op = OP_RK_START;
      S_CP_INIT:   dcmd.op = OP_CP_INIT;
      S_CP_RD:     dcmd.op = OP_CP_RD;
      S_CP_ACC:    dcmd.op = OP_CP_ACC;
      S_ST_RD:     dcmd.op = OP_ST_RD;
      S_ST_WR:     dcmd.op = OP_ST_WR;
      S_FL_RDA:    dcmd.op = OP_FL_RDA;
      S_FL_LDA:    dcmd.op = OP_FL_LDA;
      S_FL_RD:     dcmd.op = OP_FL_RD;
      S_FL_WR:     dcmd.op = OP_FL_WR;
      S_SET_STR:   dcmd.op = OP_SET_STR;
      S_EMIT:      dcmd.op = OP_EMIT;
      S_ROUND_END: dcmd.op = OP_ROUND_END;
      S_CLEAR:     dcmd.op = OP_CLEAR;
      default:     dcmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/csr_dp.sv -----
// Datapath of the ranking unit: ballot buffer, pair count and strength
// memories, Copeland tally, round masks and result register. Uses csr_pkg.
module csr_dp import csr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            dcmd,
  output dp_stat_t           stat,
  input  logic               cfg_valid,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               item_cmd,
  input  logic [IDX_W-1:0]   item_candidate,
  input  logic [VAL_W-1:0]   item_rank_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   placed_candidate,
  output logic [PLACE_W-1:0] place,
  output logic               method,
  output logic               last
);

  dp_op_t op;
  logic [IDX_W-1:0] ci, cj, ck;
  assign op = dcmd.op;
  assign ci = dcmd.ci;
  assign cj = dcmd.cj;
  assign ck = dcmd.ck;

  // configuration and active mask
  logic [CFG_W-1:0] cand_cnt, n;
  logic [NUM_CAND-1:0] act_mask, placed, rem, win;

  always_ff @(posedge clk) begin
    if (rst) cand_cnt <= CFG_RESET;
    else if (cfg_valid) cand_cnt <= cfg_data;
  end

  assign n = (cand_cnt > CFG_W'(NUM_CAND)) ? CFG_W'(NUM_CAND) : cand_cnt;

  always_comb begin
    for (int b = 0; b < NUM_CAND; b++) act_mask[b] = CFG_W'(b) < n;
  end

  assign rem = ~placed & act_mask;

  // ballot buffer, cleared through its valid bits
  logic [VAL_W-1:0] bal [NUM_CAND];
  logic [NUM_CAND-1:0] bv;
  logic [VAL_W-1:0] bal_ra, bal_rb, val_i, val_j;
  logic bva_r, bvb_r, bal_we;

  assign bal_we = (op == OP_ACCEPT) && in_valid && (item_cmd == CMD_BALLOT);

  always_ff @(posedge clk) begin
    if (bal_we) bal[item_candidate] <= item_rank_value;
    bal_ra <= bal[ci];
    bal_rb <= bal[cj];
    bva_r  <= bv[ci];
    bvb_r  <= bv[cj];
  end

  always_ff @(posedge clk) begin
    if (rst) bv <= '0;
    else if (op == OP_BAL_CLR) bv <= '0;
    else if (bal_we) bv[item_candidate] <= 1'b1;
  end

  assign val_i = bva_r ? bal_ra : '0;
  assign val_j = bvb_r ? bal_rb : '0;

  // credit selection: lower value wins, ties go to the lower index
  logic [IDX_W-1:0] ca, cb, cr_a, cr_b;
  logic cr_en_c, cr_en;

  assign ca      = (val_i < val_j) ? ci : cj;
  assign cb      = (val_i < val_j) ? cj : ci;
  assign cr_en_c = (ci > cj) && ({1'b0, ci} < n);

  always_ff @(posedge clk) begin
    if (op == OP_CR_CMP) begin
      cr_a  <= ca;
      cr_b  <= cb;
      cr_en <= cr_en_c;
    end
  end

  // pair count memory with per-entry valid bits
  logic [CNT_W-1:0] pmem [NUM_PAIRS];
  logic [NUM_PAIRS-1:0] pv;
  logic [PAIR_W-1:0] p_addr_a, p_addr_b;
  logic [CNT_W-1:0] pa_r, pb_r, pij, pji;
  logic pva_r, pvb_r, p_we;

  assign p_addr_a = (op == OP_CR_CMP) ? {ca, cb} : {ci, cj};
  assign p_addr_b = {cj, ci};
  assign pij = pva_r ? pa_r : '0;
  assign pji = pvb_r ? pb_r : '0;
  assign p_we = (op == OP_CR_WR) && cr_en && (pij != CNT_MAX);

  always_ff @(posedge clk) begin
    pa_r  <= pmem[p_addr_a];
    pb_r  <= pmem[p_addr_b];
    pva_r <= pv[p_addr_a];
    pvb_r <= pv[p_addr_b];
    if (p_we) pmem[{cr_a, cr_b}] <= pij + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else if (op == OP_CLEAR) pv <= '0;
    else if (p_we) pv[{cr_a, cr_b}] <= 1'b1;
  end

  // strength memory
  logic [CNT_W-1:0] smem [NUM_PAIRS];
  logic [PAIR_W-1:0] s_addr_a, s_addr_b, s_waddr;
  logic [CNT_W-1:0] sa_r, sb_r, sji, s_wdata, w;
  logic s_we, fl_gate;

  always_comb begin
    s_addr_a = {ci, cj};
    s_addr_b = {cj, ci};
    unique case (op)
      OP_FL_RDA: s_addr_a = {cj, ci};
      OP_FL_RD: begin
        s_addr_a = {ci, ck};
        s_addr_b = {cj, ck};
      end
      default: ;
    endcase
  end

  assign w = (sji < sa_r) ? sji : sa_r;
  assign fl_gate = rem[ci] && rem[cj] && rem[ck] && (ci != cj) && (ck != ci) && (ck != cj);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = {ci, cj};
    s_wdata = (pij > pji) ? pij : '0;
    if (op == OP_FL_WR) begin
      s_waddr = {cj, ck};
      s_wdata = w;
      s_we    = fl_gate && (w > sb_r);
    end else if (op == OP_ST_WR) begin
      s_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= smem[s_addr_a];
    sb_r <= smem[s_addr_b];
    if (s_we) smem[s_waddr] <= s_wdata;
    if (op == OP_FL_LDA) sji <= sa_r;
  end

  // Copeland tally over pair counts or strengths
  logic use_str;
  logic [PLACE_W-1:0] cnt, best, c_new, size, next_place;
  logic [CNT_W-1:0] m_ij, m_ji;
  logic gt;

  assign m_ij  = use_str ? sa_r : pij;
  assign m_ji  = use_str ? sb_r : pji;
  assign gt    = rem[ci] && rem[cj] && (m_ij > m_ji);
  assign c_new = cnt + PLACE_W'(gt);

  always_ff @(posedge clk) begin
    if (op == OP_CP_INIT) begin
      cnt  <= '0;
      best <= '0;
      win  <= '0;
    end else if (op == OP_CP_ACC) begin
      if (cj == IDX_LAST) begin
        cnt <= '0;
        if (rem[ci]) begin
          if (c_new > best) begin
            best <= c_new;
            win  <= NUM_CAND'(1) << ci;
          end else if (c_new == best) begin
            win[ci] <= 1'b1;
          end
        end
      end else begin
        cnt <= c_new;
      end
    end
  end

  // round bookkeeping
  logic load, out_free, last_c;
  logic [NUM_CAND-1:0] low;

  assign out_free = !out_valid || out_ready;
  assign load     = (op == OP_EMIT) && win[ck] && out_free;
  assign low      = (NUM_CAND'(1) << ck) - NUM_CAND'(1);
  assign last_c   = ((win & low) == '0) && ((rem & ~win) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_str    <= 1'b0;
      placed     <= '0;
      next_place <= PLACE_W'(1);
      size       <= '0;
    end else begin
      unique case (op)
        OP_RK_START, OP_CLEAR: begin
          use_str    <= 1'b0;
          placed     <= '0;
          next_place <= PLACE_W'(1);
        end
        OP_CP_INIT: size <= '0;
        OP_SET_STR: use_str <= 1'b1;
        OP_EMIT:    if (load) size <= size + PLACE_W'(1);
        OP_ROUND_END: begin
          use_str    <= 1'b0;
          placed     <= placed | win;
          next_place <= next_place + size;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      placed_candidate <= ck;
      place            <= next_place;
      method           <= use_str ? METHOD_SCHULZE : METHOD_CONDORCET;
      last             <= last_c;
    end
  end

  assign stat.n_zero     = (n == '0);
  assign stat.win_multi  = (win & (win - NUM_CAND'(1))) != '0;
  assign stat.use_str    = use_str;
  assign stat.win_e      = win[ck];
  assign stat.out_free   = out_free;
  assign stat.round_done = (rem & ~win) == '0;

  a_round_win: assert property (@(posedge clk) disable iff (rst)
    (op == OP_ROUND_END) |-> ((win != '0) && ((win & ~rem) == '0)))
    else $error("round ends with empty or stale winner set");

  a_placed_active: assert property (@(posedge clk) disable iff (rst)
    (placed & ~act_mask) == '0)
    else $error("placed mask holds an inactive candidate");

  a_counts_cleared: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CLEAR) |=> (pv == '0))
    else $error("pair counts not cleared after ranking");

endmodule

// ----- rtl/core/condorcet_schulze_ranking_unit.sv -----
// Condorcet/Schulze ranking unit: top level joining csr_ctrl and csr_dp.
// Depends on csr_pkg, csr_ctrl and csr_dp.
//
// A ballot entry without ballot_end is stored while the unit stays idle.
// An entry with ballot_end then walks all 256 ordered pairs through the
// single-write pair count memory, reading, comparing and crediting each
// active pair in turn. A rank command runs rounds until every active
// candidate is placed. Each round runs a Copeland tally over every ordered
// pair plus setup and decision; a tied round then seeds the strength
// memory, runs the widest-path sweep over the two-read, one-write strength
// memory and tallies again. Each round then scans the candidates to emit
// winners from the one-deep result register, which holds an item while the
// sink stalls, and closes the round. The configuration register is always
// ready; write it only while the unit is idle.
module condorcet_schulze_ranking_unit import csr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [IDX_W-1:0]   candidate,
  input  logic [VAL_W-1:0]   rank_value,
  input  logic               ballot_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   placed_candidate,
  output logic [PLACE_W-1:0] place,
  output logic               method,
  output logic               last
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  csr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .item_cmd        (cmd),
    .item_ballot_end (ballot_end),
    .stat            (stat),
    .in_ready        (in_ready),
    .dcmd            (dcmd)
  );

  csr_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .dcmd             (dcmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .item_cmd         (cmd),
    .item_candidate   (candidate),
    .item_rank_value  (rank_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .placed_candidate (placed_candidate),
    .place            (place),
    .method           (method),
    .last             (last)
  );

endmodule
